FILE: hw/rtl/fhh_pkg.sv
// Package for the floating-horizon hidden-line engine.
// Holds the transaction structs, command and class codes and the state type.
// No dependencies.
`default_nettype none
package fhh_pkg;

  localparam int CW = 10;
  localparam int OYW = 11;
  localparam int DEF_SCREEN_SIZE = 1024;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_CONT = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    VIS_HIDDEN = 2'd0,
    VIS_ABOVE = 2'd1,
    VIS_BELOW = 2'd2
  } vis_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CLS,
    ST_DIV,
    ST_RD,
    ST_OP,
    ST_EMIT
  } st_t;

  typedef struct packed {
    logic [1:0] cmd;
    logic [CW-1:0] px;
    logic [CW-1:0] py;
  } fhh_in_t;

  typedef struct packed {
    logic [CW-1:0] x_from;
    logic [OYW-1:0] y_from;
    logic [CW-1:0] x_to;
    logic [OYW-1:0] y_to;
    logic last;
  } fhh_out_t;

endpackage
`default_nettype wire

FILE: hw/rtl/floating_horizon_hidden_line_top.sv
// Floating-horizon hidden-line engine, top level with result register.
// A start or vertical step runs no division; a step that draws runs one division
// per crossing search and per drawn part and walks the horizon memory one column
// at a time, read then updated, whose single read port sets that pace.
// After reset and after a clear transaction the horizon memory is swept over all
// SCREEN_SIZE columns, during which no input transaction is accepted.
`default_nettype none
module floating_horizon_hidden_line_top #(
  parameter int SCREEN_SIZE = fhh_pkg::DEF_SCREEN_SIZE
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire fhh_pkg::fhh_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output fhh_pkg::fhh_out_t      out_data
);
  import fhh_pkg::*;

  localparam int AW = $clog2(SCREEN_SIZE);
  localparam int HW = $clog2(SCREEN_SIZE + 1);
  localparam int EW = (HW > CW) ? HW : CW;

  logic seg_valid, seg_ready, rd_en, wr_en;
  fhh_out_t seg_data;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [2*EW-1:0] rd_data, wr_data;
  logic out_valid_r, out_valid_nxt;
  fhh_out_t out_data_r, out_data_nxt;

  fhh_hmem #(.DEPTH(SCREEN_SIZE), .AW(AW), .DW(2*EW)) u_mem (
    .clk(clk), .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  fhh_engine #(.SCREEN_SIZE(SCREEN_SIZE), .AW(AW), .EW(EW)) u_eng (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .seg_valid(seg_valid), .seg_ready(seg_ready), .seg_data(seg_data),
    .rd_en(rd_en), .rd_addr(rd_addr), .rd_data(rd_data),
    .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data)
  );

  assign seg_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt = out_data_r;
    if (seg_valid && seg_ready) begin
      out_valid_nxt = 1'b1;
      out_data_nxt = seg_data;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule
`default_nettype wire

FILE: hw/rtl/fhh_hmem.sv
// Horizon memory: one word per screen column holding the upper and lower horizon.
// Synchronous, one write and one registered read per cycle. Uses no package.
`default_nettype none
module fhh_hmem #(
  parameter int DEPTH = 1024,
  parameter int AW = 10,
  parameter int DW = 22
) (
  input  wire logic          clk,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [DW-1:0] rd_data,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [DW-1:0] wr_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/fhh_div.sv
// Iterative restoring divider, one quotient bit per cycle.
// Depends on fhh_pkg for the operand width.
`default_nettype none
module fhh_div (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [fhh_pkg::CW-1:0] num,
  input  wire logic [fhh_pkg::CW-1:0] den,
  output logic                       done,
  output logic      [fhh_pkg::CW-1:0] quo,
  output logic      [fhh_pkg::CW-1:0] rem
);
  import fhh_pkg::*;

  logic [CW-1:0] quo_r, quo_nxt, rem_r, rem_nxt, den_r, den_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [CW:0] sh;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    sh = {rem_r, quo_r[CW-1]};
    if (start) begin
      quo_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = 4'(CW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (sh >= {1'b0, den_r}) begin
        rem_nxt = CW'(sh - {1'b0, den_r});
        quo_nxt = {quo_r[CW-2:0], 1'b1};
      end else begin
        rem_nxt = sh[CW-1:0];
        quo_nxt = {quo_r[CW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 4'd1;
      if (cnt_r == 4'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = quo_r;
  assign rem = rem_r;

endmodule
`default_nettype wire

FILE: hw/rtl/fhh_engine.sv
// Sequencer of the hidden-line engine: classification, crossing search and
// horizon raising over the horizon memory. Depends on fhh_pkg and fhh_div.
`default_nettype none
module fhh_engine #(
  parameter int SCREEN_SIZE = fhh_pkg::DEF_SCREEN_SIZE,
  parameter int AW = 10,
  parameter int EW = 11
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire fhh_pkg::fhh_in_t    in_data,
  output logic                     seg_valid,
  input  wire logic                seg_ready,
  output fhh_pkg::fhh_out_t        seg_data,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  wire logic [2*EW-1:0]     rd_data,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [2*EW-1:0]          wr_data
);
  import fhh_pkg::*;

  st_t state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [CW-1:0] px_r, px_nxt, py_r, py_nxt, nx_r, nx_nxt, ny_r, ny_nxt;
  vis_t pv_r, pv_nxt, cv_r, cv_nxt;
  logic is_start_r, is_start_nxt;
  logic two_r, two_nxt, upper_r, upper_nxt, c2n_r, c2n_nxt, last_r, last_nxt;
  logic raise_r, raise_nxt, first_r, first_nxt, side_r, side_nxt;
  logic neg_r, neg_nxt, go_r, go_nxt;
  logic [CW-1:0] wax_r, wax_nxt, way_r, way_nxt, wbx_r, wbx_nxt, wby_r, wby_nxt;
  logic [CW-1:0] col_r, col_nxt, r_r, r_nxt, dr_r, dr_nxt, dd_r, dd_nxt;
  logic signed [11:0] q_r, q_nxt, dq_r, dq_nxt;

  logic div_done;
  logic [CW-1:0] div_q, div_rem;
  logic signed [CW:0] dy, dx;
  logic [CW-1:0] ady, adx;
  logic [EW-1:0] h_up, h_lo, h_sel, yext, in_yext;
  logic oob, in_oob, ge, rnd, adv;
  logic signed [11:0] base, ysum;
  logic [CW-1:0] ycur;
  logic [CW:0] rsum, twice_r;
  vis_t cls;

  assign dy = $signed({1'b0, wby_r}) - $signed({1'b0, way_r});
  assign dx = $signed({1'b0, wbx_r}) - $signed({1'b0, wax_r});
  assign ady = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign adx = dx[CW] ? CW'(-dx) : dx[CW-1:0];

  fhh_div u_div (
    .clk(clk), .rst_n(rst_n), .start(go_r), .num(ady), .den(adx),
    .done(div_done), .quo(div_q), .rem(div_rem)
  );

  assign oob = {22'd0, col_r} >= 32'(SCREEN_SIZE);
  assign in_oob = {22'd0, nx_r} >= 32'(SCREEN_SIZE);
  assign h_up = ((state_r == ST_CLS) ? in_oob : oob) ? '0 : rd_data[2*EW-1:EW];
  assign h_lo = ((state_r == ST_CLS) ? in_oob : oob) ? EW'(SCREEN_SIZE) : rd_data[EW-1:0];
  assign h_sel = upper_r ? h_up : h_lo;

  assign base = $signed({2'b00, way_r}) + q_r;
  assign twice_r = {r_r, 1'b0};
  assign rnd = (r_r != '0) && ((twice_r > {1'b0, dd_r}) ||
               ((twice_r == {1'b0, dd_r}) && base[0]));
  assign ysum = base + (rnd ? 12'sd1 : 12'sd0);
  assign ycur = ysum[CW-1:0];
  assign yext = EW'(ycur);
  assign ge = yext >= h_sel;
  assign rsum = {1'b0, r_r} + {1'b0, dr_r};
  assign in_yext = EW'(ny_r);

  always_comb begin
    if ((in_yext < h_up) && (in_yext > h_lo)) begin
      cls = VIS_HIDDEN;
    end else if (in_yext >= h_up) begin
      cls = VIS_ABOVE;
    end else begin
      cls = VIS_BELOW;
    end
  end

  always_comb begin
    state_nxt = state_r;
    clr_nxt = clr_r;
    px_nxt = px_r; py_nxt = py_r; nx_nxt = nx_r; ny_nxt = ny_r;
    pv_nxt = pv_r; cv_nxt = cv_r; is_start_nxt = is_start_r;
    two_nxt = two_r; upper_nxt = upper_r; c2n_nxt = c2n_r; last_nxt = last_r;
    raise_nxt = raise_r; first_nxt = first_r; side_nxt = side_r;
    neg_nxt = neg_r; go_nxt = 1'b0;
    wax_nxt = wax_r; way_nxt = way_r; wbx_nxt = wbx_r; wby_nxt = wby_r;
    col_nxt = col_r; r_nxt = r_r; dr_nxt = dr_r; dd_nxt = dd_r;
    q_nxt = q_r; dq_nxt = dq_r;
    in_ready = 1'b0;
    seg_valid = 1'b0;
    rd_en = 1'b0;
    rd_addr = AW'(col_r);
    wr_en = 1'b0;
    wr_addr = AW'(col_r);
    wr_data = {(yext > h_up) ? yext : h_up, (yext < h_lo) ? yext : h_lo};
    adv = 1'b0;

    unique case (state_r)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_r;
        wr_data = {EW'(0), EW'(SCREEN_SIZE)};
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(SCREEN_SIZE - 1)) begin
          clr_nxt = '0;
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        rd_addr = AW'(in_data.px);
        if (in_valid) begin
          nx_nxt = in_data.px;
          ny_nxt = in_data.py;
          is_start_nxt = (in_data.cmd == CMD_START);
          if (in_data.cmd == CMD_CLEAR) begin
            state_nxt = ST_CLEAR;
          end else if (in_data.cmd == CMD_START || in_data.cmd == CMD_CONT) begin
            rd_en = 1'b1;
            state_nxt = ST_CLS;
          end
        end
      end
      ST_CLS: begin
        cv_nxt = cls;
        state_nxt = ST_IDLE;
        two_nxt = 1'b0;
        last_nxt = 1'b1;
        wax_nxt = px_r; way_nxt = py_r; wbx_nxt = nx_r; wby_nxt = ny_r;
        raise_nxt = 1'b0;
        if (is_start_r) begin
          px_nxt = nx_r; py_nxt = ny_r; pv_nxt = cls;
        end else if (nx_r == px_r) begin
          wr_en = !in_oob;
          wr_addr = AW'(nx_r);
          wr_data = {(in_yext > h_up) ? in_yext : h_up, (in_yext < h_lo) ? in_yext : h_lo};
          px_nxt = nx_r; py_nxt = ny_r; pv_nxt = cls;
        end else if (cls == pv_r) begin
          if (cls == VIS_HIDDEN) begin
            px_nxt = nx_r; py_nxt = ny_r; pv_nxt = cls;
          end else begin
            state_nxt = ST_EMIT;
          end
        end else begin
          go_nxt = 1'b1;
          state_nxt = ST_DIV;
          if (cls == VIS_HIDDEN) begin
            upper_nxt = (pv_r == VIS_ABOVE);
            c2n_nxt = 1'b0;
          end else if (pv_r == VIS_HIDDEN) begin
            upper_nxt = (cls == VIS_ABOVE);
            c2n_nxt = 1'b1;
          end else begin
            upper_nxt = (cls == VIS_BELOW);
            c2n_nxt = 1'b0;
            last_nxt = 1'b0;
            two_nxt = 1'b1;
          end
        end
      end
      ST_DIV: begin
        if (div_done) begin
          neg_nxt = dx[CW];
          dd_nxt = adx;
          if (dy[CW]) begin
            dq_nxt = -($signed({2'b00, div_q}) + ((div_rem != '0) ? 12'sd1 : 12'sd0));
            dr_nxt = (div_rem != '0) ? adx - div_rem : '0;
          end else begin
            dq_nxt = $signed({2'b00, div_q});
            dr_nxt = div_rem;
          end
          col_nxt = wax_r;
          q_nxt = '0;
          r_nxt = '0;
          first_nxt = 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        rd_en = 1'b1;
        state_nxt = ST_OP;
      end
      ST_OP: begin
        if (raise_r) begin
          wr_en = !oob;
          if (col_r == wbx_r) begin
            if (two_r) begin
              two_nxt = 1'b0;
              upper_nxt = !upper_r;
              c2n_nxt = 1'b1;
              last_nxt = 1'b1;
              raise_nxt = 1'b0;
              wax_nxt = px_r; way_nxt = py_r; wbx_nxt = nx_r; wby_nxt = ny_r;
              go_nxt = 1'b1;
              state_nxt = ST_DIV;
            end else begin
              px_nxt = nx_r; py_nxt = ny_r; pv_nxt = cv_r;
              state_nxt = ST_IDLE;
            end
          end else begin
            adv = 1'b1;
          end
        end else begin
          first_nxt = 1'b0;
          if ((first_r && yext == h_sel) || (!first_r && ge != side_r) ||
              col_r == wbx_r) begin
            if (c2n_r) begin
              wax_nxt = col_r; way_nxt = ycur; wbx_nxt = nx_r; wby_nxt = ny_r;
            end else begin
              wax_nxt = px_r; way_nxt = py_r; wbx_nxt = col_r; wby_nxt = ycur;
            end
            state_nxt = ST_EMIT;
          end else begin
            if (first_r) begin
              side_nxt = ge;
            end
            adv = 1'b1;
          end
        end
        if (adv) begin
          col_nxt = neg_r ? col_r - CW'(1) : col_r + CW'(1);
          if (rsum >= {1'b0, dd_r}) begin
            r_nxt = CW'(rsum - {1'b0, dd_r});
            q_nxt = q_r + dq_r + 12'sd1;
          end else begin
            r_nxt = rsum[CW-1:0];
            q_nxt = q_r + dq_r;
          end
          state_nxt = ST_RD;
        end
      end
      ST_EMIT: begin
        seg_valid = 1'b1;
        if (seg_ready) begin
          raise_nxt = 1'b1;
          go_nxt = 1'b1;
          state_nxt = ST_DIV;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    seg_data.x_from = wax_r;
    seg_data.y_from = {1'b0, way_r};
    seg_data.x_to = wbx_r;
    seg_data.y_to = {1'b0, wby_r};
    seg_data.last = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r <= '0;
      px_r <= '0;
      py_r <= '0;
      pv_r <= VIS_HIDDEN;
      two_r <= 1'b0;
      go_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_r <= clr_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
      pv_r <= pv_nxt;
      two_r <= two_nxt;
      go_r <= go_nxt;
    end
    nx_r <= nx_nxt; ny_r <= ny_nxt; cv_r <= cv_nxt; is_start_r <= is_start_nxt;
    upper_r <= upper_nxt; c2n_r <= c2n_nxt; last_r <= last_nxt;
    raise_r <= raise_nxt; first_r <= first_nxt; side_r <= side_nxt; neg_r <= neg_nxt;
    wax_r <= wax_nxt; way_r <= way_nxt; wbx_r <= wbx_nxt; wby_r <= wby_nxt;
    col_r <= col_nxt; r_r <= r_nxt; dr_r <= dr_nxt; dd_r <= dd_nxt;
    q_r <= q_nxt; dq_r <= dq_nxt;
  end

endmodule
`default_nettype wire
